[design/tclp_pkg.sv]
// Shared constants, types and helpers for the time-code line parser.
`timescale 1ns / 1ps
`default_nettype none

package tclp_pkg;

	localparam int LINE_MAX = 32;
	localparam int POS_W = $clog2(LINE_MAX);

	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;
	localparam int LIMIT_W = 4;

	localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(23);
	localparam logic [POS_W-1:0] SUM_END = POS_W'(21);
	localparam logic [POS_W-1:0] DIGIT_FIRST = POS_W'(2);
	localparam logic [POS_W-1:0] DIGIT_END = POS_W'(18);
	localparam logic [POS_W-1:0] LEAP_POS = POS_W'(18);
	localparam logic [POS_W-1:0] VALID_POS = POS_W'(19);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_MAX - 1);

	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DELETE = 8'h7f;
	localparam logic [7:0] CHAR_T = 8'h54;
	localparam logic [7:0] CHAR_TWO = 8'h32;
	localparam logic [7:0] CHAR_E = 8'h45;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_PLUS = 8'h2b;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [1:0] {
		LEAP_NONE = 2'd0,
		LEAP_FORWARD = 2'd1,
		LEAP_BACKWARD = 2'd2,
		LEAP_OTHER = 2'd3
	} leap_code_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [7:0] sum;
		logic [7:0] older;
		logic [7:0] newest;
		logic [15:0][3:0] digits;
		logic [7:0] leap;
		logic [7:0] valid;
		logic [3:0] flags;
	} line_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CHAR_ZERO + {4'd0, nib};
		end else begin
			ch = 8'h37 + {4'd0, nib};
		end
		return ch;
	endfunction

	function automatic logic [7:0] digit_pair(input logic [3:0] tens, input logic [3:0] units);
		return 8'({4'd0, tens} * 8'd10) + {4'd0, units};
	endfunction

endpackage

`default_nettype wire

[design/time_code_line_parser_top.sv]
// Time-code line parser: line tracking, checksum check and field decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received character per clock cycle on the slave stream while it is
// ready, and emits one decoded result per ended line (newline, or the line store
// filling up) on the master stream, in the cycle after the ending character is
// taken. Every byte is handled by the update logic between the line registers and
// the result register, so a byte can be taken every cycle while the result
// register is empty or being drained at the same edge. The frequency-figure limit
// is written on the cfg channel, which is always ready.
module time_code_line_parser_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// rx_byte[7:0]
	input  wire logic [tclp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// year[14:0], month[22:15], day_of_month[30:23], hour[38:31],
	// minute[46:39], second[54:47], time_figure[58:55], freq_figure[62:59],
	// leap_code[64:63], time_good[65], zero fill[71:66]
	output logic [tclp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// frame_good[0], error_line[1]
	output logic [tclp_pkg::OUT_USER_W-1:0]        m_axis_tuser,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	// freq_figure_limit[3:0]
	input  wire logic [tclp_pkg::LIMIT_W-1:0]      cfg_data
);
	import tclp_pkg::*;

	line_state_t line_q;
	line_state_t upd;
	line_state_t clr;
	logic [LIMIT_W-1:0] limit_q;
	logic m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	logic [7:0] ch;
	logic take;
	logic is_newline;
	logic is_kept;
	logic line_done;
	logic frame_good;
	logic error_line;
	logic [14:0] year;
	logic [7:0] month;
	logic [7:0] day_of_month;
	logic [7:0] hour;
	logic [7:0] minute;
	logic [7:0] second;
	logic [3:0] time_figure;
	logic [3:0] freq_figure;
	leap_code_t leap_code;
	logic time_good;
	logic [3:0] digit_idx;

	assign ch = s_axis_tdata;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign is_newline = (ch == CHAR_NEWLINE);
	assign is_kept = (ch >= CHAR_SPACE) && (ch != CHAR_DELETE);
	assign digit_idx = 4'(line_q.pos - DIGIT_FIRST);
	assign clr = '0;

	always_comb begin
		upd = line_q;
		if (is_kept) begin
			if (line_q.pos == '0) begin
				if (ch == CHAR_T) upd.flags[0] = 1'b1;
				if (ch == CHAR_E) upd.flags[2] = 1'b1;
			end else if (line_q.pos == POS_W'(1)) begin
				if (ch == CHAR_TWO) upd.flags[1] = 1'b1;
				if (ch == CHAR_MINUS) upd.flags[3] = 1'b1;
			end
			if (line_q.pos < SUM_END) begin
				upd.sum = line_q.sum + ch;
			end
			if (line_q.pos >= DIGIT_FIRST && line_q.pos < DIGIT_END) begin
				upd.digits[digit_idx] = ch[3:0];
			end
			if (line_q.pos == LEAP_POS) begin
				upd.leap = ch;
			end
			if (line_q.pos == VALID_POS) begin
				upd.valid = ch;
			end
			upd.older = line_q.newest;
			upd.newest = ch;
			upd.pos = line_q.pos + POS_W'(1);
		end
	end

	assign line_done = is_newline || (is_kept && upd.pos == LAST_POS);

	always_comb begin
		frame_good = (upd.pos == FRAME_LEN) && (upd.flags[1:0] == 2'b11) &&
			(upd.older == hex_char(upd.sum[7:4])) && (upd.newest == hex_char(upd.sum[3:0]));
		error_line = (upd.flags[3:2] == 2'b11);
		year = '0;
		month = '0;
		day_of_month = '0;
		hour = '0;
		minute = '0;
		second = '0;
		time_figure = '0;
		freq_figure = '0;
		leap_code = LEAP_NONE;
		time_good = 1'b0;
		if (frame_good) begin
			year = 15'({11'd0, upd.digits[0]} * 15'd1000) +
				15'({11'd0, upd.digits[1]} * 15'd100) +
				15'({11'd0, upd.digits[2]} * 15'd10) + {11'd0, upd.digits[3]};
			month = digit_pair(upd.digits[4], upd.digits[5]);
			day_of_month = digit_pair(upd.digits[6], upd.digits[7]);
			hour = digit_pair(upd.digits[8], upd.digits[9]);
			minute = digit_pair(upd.digits[10], upd.digits[11]);
			second = digit_pair(upd.digits[12], upd.digits[13]);
			time_figure = upd.digits[14];
			freq_figure = upd.digits[15];
			if (upd.leap == CHAR_ZERO) begin
				leap_code = LEAP_NONE;
			end else if (upd.leap == CHAR_PLUS) begin
				leap_code = LEAP_FORWARD;
			end else if (upd.leap == CHAR_MINUS) begin
				leap_code = LEAP_BACKWARD;
			end else begin
				leap_code = LEAP_OTHER;
			end
			time_good = (upd.valid == CHAR_ZERO) && (upd.digits[15] < limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			limit_q <= LIMIT_W'(3);
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (take) begin
				line_q <= line_done ? clr : upd;
			end
			if (take && line_done) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && line_done) begin
			m_data_q <= {6'd0, time_good, leap_code, freq_figure, time_figure, second,
				minute, hour, day_of_month, month, year};
			m_user_q <= {error_line, frame_good};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

endmodule

`default_nettype wire
